// ===== sv/dht_pkg.sv =====
// Package for the device health table: sizes, action and health codes,
// the table entry layout and the controller state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dht_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ID_W     = 64;
    localparam int STAMP_W  = 32;
    localparam int ACTION_W = 3;

    localparam logic [ACTION_W-1:0] ACT_QUERY     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PROBING   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEAD      = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ALIVE     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CONDEMNED = 3'd4;

    typedef enum logic [1:0] {
        H_NORMAL    = 2'd0,
        H_PROBING   = 2'd1,
        H_DEAD      = 2'd2,
        H_CONDEMNED = 2'd3
    } t_health;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        t_health            health;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MISS
    } t_state;

endpackage

`default_nettype wire

// ===== sv/dht_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dht_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 98
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== sv/device_health_table_top.sv =====
// Device health table top level: scan controller, result register and the entry RAM.
// Depends on dht_pkg and dht_ram.
//
// One item is handled at a time. The accept cycle starts a linear scan over the used
// entries through the single read port of the entry RAM, comparing one entry per cycle.
// An id found at position k finishes with the compare of entry k; an id that is not
// found finishes in the miss state after all used entries, at most TABLE_ENTRIES, were
// compared. The update is written back in the finishing cycle and the result goes to an
// output register, so the next item may be taken while the previous result still waits.
// A result that cannot yet be loaded holds the controller in its finishing state.
`timescale 1ns / 1ps
`default_nettype none

module device_health_table_top
    import dht_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [ACTION_W-1:0] i_action,
    input  wire logic [ID_W-1:0]     i_device_id,
    input  wire logic [STAMP_W-1:0]  i_now_seconds,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic [1:0]               o_health,
    output logic                     o_found,
    output logic                     o_blacklisted,
    output logic [STAMP_W-1:0]       o_probe_stamp,
    output logic                     o_dropped
);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_used, n_used;
    logic [ACTION_W-1:0]  r_action;
    logic [ID_W-1:0]      r_id;
    logic [STAMP_W-1:0]   r_now;

    logic                 r_out_valid, n_out_valid;
    t_health              r_res_health, n_res_health;
    logic                 r_res_found, n_res_found;
    logic [STAMP_W-1:0]   r_res_stamp, n_res_stamp;
    logic                 r_res_dropped, n_res_dropped;

    logic                 in_xfer;
    logic                 out_free;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    t_entry               mem_wdata;
    t_entry               rd_entry;
    logic [ENTRY_W-1:0]   rd_raw;

    logic                 is_mark;
    t_health              target;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_entry = t_entry'(rd_raw);

    always_comb begin
        is_mark = 1'b1;
        target  = H_NORMAL;
        unique case (r_action)
            ACT_PROBING:   target = H_PROBING;
            ACT_DEAD:      target = H_DEAD;
            ACT_ALIVE:     target = H_NORMAL;
            ACT_CONDEMNED: target = H_CONDEMNED;
            default:       is_mark = 1'b0;
        endcase
    end

    // The RAM address follows the next index, so the entry compared in the scan state
    // is always the one at r_idx, also while the state holds for a stalled result.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_used        = r_used;
        n_out_valid   = r_out_valid && i_out_stall;
        n_res_health  = r_res_health;
        n_res_found   = r_res_found;
        n_res_stamp   = r_res_stamp;
        n_res_dropped = r_res_dropped;
        mem_we        = 1'b0;
        mem_waddr     = r_idx;
        mem_wdata     = rd_entry;
        o_in_stall    = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_idx   = '0;
                    n_state = (r_used == '0) ? ST_MISS : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_entry.id == r_id) begin
                    if (out_free) begin
                        n_out_valid   = 1'b1;
                        n_res_found   = 1'b1;
                        n_res_dropped = 1'b0;
                        n_res_health  = rd_entry.health;
                        n_res_stamp   = rd_entry.stamp;
                        // A dead entry ignores a probing mark.
                        if (is_mark && !(target == H_PROBING && rd_entry.health == H_DEAD)) begin
                            mem_we           = 1'b1;
                            mem_wdata.health = target;
                            if (target == H_PROBING) begin
                                mem_wdata.stamp = r_now;
                            end
                            n_res_health = target;
                            n_res_stamp  = mem_wdata.stamp;
                        end
                        n_state = ST_IDLE;
                    end
                end else if (CNT_W'(r_idx) + CNT_W'(1) == r_used) begin
                    n_state = ST_MISS;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_MISS: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_res_found   = 1'b0;
                    n_res_dropped = 1'b0;
                    n_res_health  = H_NORMAL;
                    n_res_stamp   = '0;
                    if (is_mark) begin
                        if (r_used < CNT_W'(TABLE_ENTRIES)) begin
                            mem_we           = 1'b1;
                            mem_waddr        = r_used[IDX_W-1:0];
                            mem_wdata.id     = r_id;
                            mem_wdata.health = target;
                            mem_wdata.stamp  = (target == H_PROBING) ? r_now : '0;
                            n_used           = r_used + CNT_W'(1);
                            n_res_health     = target;
                            n_res_stamp      = mem_wdata.stamp;
                        end else begin
                            n_res_dropped = 1'b1;
                        end
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_res_health  <= n_res_health;
        r_res_found   <= n_res_found;
        r_res_stamp   <= n_res_stamp;
        r_res_dropped <= n_res_dropped;
        if (in_xfer) begin
            r_action <= i_action;
            r_id     <= i_device_id;
            r_now    <= i_now_seconds;
        end
    end

    // The write-back always lands before the next scan reads, so no forwarding is needed.
    dht_ram #(
        .DEPTH (TABLE_ENTRIES),
        .AW    (IDX_W),
        .DW    (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (ENTRY_W'(mem_wdata)),
        .i_raddr (n_idx),
        .o_rdata (rd_raw)
    );

    assign o_out_valid   = r_out_valid;
    assign o_health      = r_res_health;
    assign o_found       = r_res_found;
    assign o_blacklisted = (r_res_health == H_DEAD) || (r_res_health == H_CONDEMNED);
    assign o_probe_stamp = r_res_stamp;
    assign o_dropped     = r_res_dropped;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_write_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("table write without a finished result");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (CNT_W'(r_idx) < r_used))
        else $error("scan index past the used entries");

    a_drop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res_dropped) |-> (!r_res_found && r_res_health == H_NORMAL
            && r_used == CNT_W'(TABLE_ENTRIES)))
        else $error("dropped result inconsistent");

endmodule

`default_nettype wire
